// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the crossfade mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/tsmix_pkg.sv -----
// Types and constants of the three-stem crossfade mixer.
`default_nettype none
package tsmix_pkg;

    localparam int STEMS       = 3;
    localparam int UNITY       = 8192;
    localparam int UNITY_SHIFT = 13;
    localparam int PEAK_SPAN   = UNITY * 2;
    localparam int GAIN_W      = UNITY_SHIFT + 1;
    localparam int QUOT_W      = 17;

    localparam logic [1:0] STEP_PHASE = 2'd0;

    typedef struct packed {
        logic        [14:0] target_mix;
        logic signed [15:0] stem0_left;
        logic signed [15:0] stem0_right;
        logic signed [15:0] stem1_left;
        logic signed [15:0] stem1_right;
        logic signed [15:0] stem2_left;
        logic signed [15:0] stem2_right;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] mixed_left;
        logic signed [15:0] mixed_right;
    } mix_t;

    typedef struct packed {
        logic signed [QUOT_W-1:0] q_left;
        logic signed [QUOT_W-1:0] q_right;
    } lane_q_t;

    typedef struct packed {
        logic adv;
        logic valid;
    } pipe_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tsmix_lane.sv -----
// One stem lane: triangular window gain, then scaled left and right samples.
`default_nettype none
module tsmix_lane #(
    parameter int STEM = 0
) (
    input  wire logic                     clk,
    input  wire logic                     adv,
    input  wire logic signed [15:0]       mix_pos,
    input  wire logic signed [15:0]       left,
    input  wire logic signed [15:0]       right,
    output tsmix_pkg::lane_q_t            q
);

    localparam logic signed [16:0] OFFSET = 17'(STEM * tsmix_pkg::UNITY);
    localparam logic signed [16:0] UNITY17 = 17'(tsmix_pkg::UNITY);
    localparam logic signed [16:0] SPAN17 = 17'(tsmix_pkg::PEAK_SPAN);

    logic signed [16:0]                m_raw;
    logic signed [16:0]                m_mirror;
    logic signed [16:0]                m_sel;
    logic [tsmix_pkg::GAIN_W-1:0]      gain_next;
    logic [tsmix_pkg::GAIN_W-1:0]      gain_reg;
    logic signed [15:0]                left_reg;
    logic signed [15:0]                right_reg;
    logic signed [30:0]                prod_l;
    logic signed [30:0]                prod_r;
    tsmix_pkg::lane_q_t                q_next;
    tsmix_pkg::lane_q_t                q_reg;

    // divide by unity, truncating toward zero
    function automatic logic signed [tsmix_pkg::QUOT_W-1:0] scale_down(
        input logic signed [30:0] p
    );
        logic signed [30:0] sh;
        logic               fix;
        sh  = p >>> tsmix_pkg::UNITY_SHIFT;
        fix = p[30] && (p[tsmix_pkg::UNITY_SHIFT-1:0] != '0);
        return sh[tsmix_pkg::QUOT_W-1:0] + tsmix_pkg::QUOT_W'(fix);
    endfunction

    always_comb
    begin
        m_raw     = {mix_pos[15], mix_pos} - OFFSET;
        m_mirror  = SPAN17 - m_raw;
        m_sel     = (m_raw > UNITY17) ? m_mirror : m_raw;
        gain_next = m_sel[16] ? '0 : m_sel[tsmix_pkg::GAIN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gain_reg  <= gain_next;
            left_reg  <= left;
            right_reg <= right;
        end
    end

    always_comb
    begin
        prod_l        = left_reg * $signed({1'b0, gain_reg});
        prod_r        = right_reg * $signed({1'b0, gain_reg});
        q_next.q_left  = scale_down(prod_l);
        q_next.q_right = scale_down(prod_r);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/tsmix_merge.sv -----
// Merge stage: sums the lane results per side into the output register.
`default_nettype none
`include "assert_macros.svh"
module tsmix_merge (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tsmix_pkg::pipe_ctl_t  ctl,
    input  wire tsmix_pkg::lane_q_t    lane_q [tsmix_pkg::STEMS],
    output logic                       mix_valid,
    output tsmix_pkg::mix_t            mix
);

    logic signed [18:0] sum_l;
    logic signed [18:0] sum_r;
    logic               valid_reg;
    tsmix_pkg::mix_t    mix_reg;

    always_comb
    begin
        sum_l = '0;
        sum_r = '0;
        for (int i = 0; i < tsmix_pkg::STEMS; i++)
        begin
            sum_l = sum_l + {{2{lane_q[i].q_left[16]}}, lane_q[i].q_left};
            sum_r = sum_r + {{2{lane_q[i].q_right[16]}}, lane_q[i].q_right};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            mix_reg.mixed_left  <= sum_l[15:0];
            mix_reg.mixed_right <= sum_r[15:0];
        end
    end

    assign mix_valid = valid_reg;
    assign mix       = mix_reg;

    `ASSERT_NEXT(a_merge_load, clk, rst_n, ctl.valid && ctl.adv, valid_reg)
    `ASSERT_NEXT(a_merge_hold, clk, rst_n, !ctl.adv, $stable(valid_reg))

endmodule
`default_nettype wire

// ----- hw/rtl/three_stem_music_crossfade_mixer.sv -----
// Top level of the three-stem crossfade mixer: mix state, lanes and merge.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  frame    | frame_valid  | frame_stall  | frame (tsmix_pkg::frame_t)
//  mix      | mix_valid    | mix_stall    | mix   (tsmix_pkg::mix_t)
//
//  One request per cycle while no result waits under mix_stall.
//  Stages: mix update, gain per lane, multiply and scale per lane, merge sum.
//  The whole pipeline holds while a result waits under mix_stall.
//  Reset clears mix position, frame phase and the stage valid bits.
`default_nettype none
`include "assert_macros.svh"
module three_stem_music_crossfade_mixer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                frame_valid,
    output logic                     frame_stall,
    input  wire tsmix_pkg::frame_t   frame,
    output logic                     mix_valid,
    input  wire logic                mix_stall,
    output tsmix_pkg::mix_t          mix
);

    logic                     adv;
    logic                     accept;
    logic signed [15:0]       mix_position_reg;
    logic signed [15:0]       mix_position_next;
    logic [1:0]               frame_phase_reg;
    logic [1:0]               frame_phase_next;
    logic signed [15:0]       s1_mix_reg;
    logic signed [15:0]       s1_left_reg  [tsmix_pkg::STEMS];
    logic signed [15:0]       s1_right_reg [tsmix_pkg::STEMS];
    logic signed [15:0]       stem_left    [tsmix_pkg::STEMS];
    logic signed [15:0]       stem_right   [tsmix_pkg::STEMS];
    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     s3_valid_reg;
    tsmix_pkg::lane_q_t       lane_q [tsmix_pkg::STEMS];
    tsmix_pkg::pipe_ctl_t     merge_ctl;

    assign adv         = !(mix_valid && mix_stall);
    assign frame_stall = !adv;
    assign accept      = frame_valid && adv;

    always_comb
    begin
        stem_left[0]  = frame.stem0_left;
        stem_right[0] = frame.stem0_right;
        stem_left[1]  = frame.stem1_left;
        stem_right[1] = frame.stem1_right;
        stem_left[2]  = frame.stem2_left;
        stem_right[2] = frame.stem2_right;
    end

    // on the first frame of each group of four, step up if the target is above the mix position, else step down
    always_comb
    begin
        mix_position_next = mix_position_reg;
        if (frame_phase_reg == tsmix_pkg::STEP_PHASE)
        begin
            if ($signed({2'b00, frame.target_mix}) >
                $signed({mix_position_reg[15], mix_position_reg}))
            begin
                mix_position_next = mix_position_reg + 16'sd1;
            end
            else
            begin
                mix_position_next = mix_position_reg - 16'sd1;
            end
        end
        frame_phase_next = frame_phase_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_position_reg <= '0;
            frame_phase_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mix_position_reg <= mix_position_next;
                frame_phase_reg  <= frame_phase_next;
            end
            if (adv)
            begin
                s1_valid_reg <= frame_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mix_reg <= mix_position_next;
            for (int i = 0; i < tsmix_pkg::STEMS; i++)
            begin
                s1_left_reg[i]  <= stem_left[i];
                s1_right_reg[i] <= stem_right[i];
            end
        end
    end

    for (genvar g = 0; g < tsmix_pkg::STEMS; g++)
    begin : g_lane
        tsmix_lane #(
            .STEM (g)
        ) u_lane (
            .clk     (clk),
            .adv     (adv),
            .mix_pos (s1_mix_reg),
            .left    (s1_left_reg[g]),
            .right   (s1_right_reg[g]),
            .q       (lane_q[g])
        );
    end

    assign merge_ctl.adv   = adv;
    assign merge_ctl.valid = s3_valid_reg;

    tsmix_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (merge_ctl),
        .lane_q    (lane_q),
        .mix_valid (mix_valid),
        .mix       (mix)
    );

    `ASSERT_ALWAYS(a_mix_range, clk, rst_n, !mix_position_reg[15] || (mix_position_reg == -16'sd1))
    `ASSERT_NEXT(a_phase_step, clk, rst_n, accept, frame_phase_reg == 2'($past(frame_phase_reg) + 2'd1))
    `ASSERT_NEXT(a_mix_hold, clk, rst_n, !accept || (frame_phase_reg != tsmix_pkg::STEP_PHASE), $stable(mix_position_reg))
    `ASSERT_IMPLY(a_no_stall_empty, clk, rst_n, frame_stall, mix_valid)

endmodule
`default_nettype wire

// ----- test/tb_three_stem_music_crossfade_mixer.sv -----
// Self-checking testbench for the three-stem crossfade mixer: edge-value and random frames against a predictor.
`timescale 1ns / 100ps
module tb_three_stem_music_crossfade_mixer;

    localparam int     RANDOM_FRAMES = 700;
    localparam int     SWEEP_FRAMES  = 200;
    localparam int     HIGH_FRAMES   = 100;
    localparam int     LATENCY       = 4;
    localparam longint CYCLE_LIMIT   = 1000000;

    typedef struct {
        tsmix_pkg::frame_t f;
        bit                drain;
    } pending_t;

    logic              clk;
    logic              rst_n;
    logic              frame_valid;
    logic              frame_stall;
    tsmix_pkg::frame_t frame;
    logic              mix_valid;
    logic              mix_stall;
    tsmix_pkg::mix_t   mix;

    pending_t        pending_frames[$];
    tsmix_pkg::mix_t expected_mix[$];

    logic signed [15:0] mix_pos;
    logic        [1:0]  frame_ph;
    logic               frame_acc;
    int                 gap_left;
    int                 stall_left;
    int                 tx_calm;
    int                 rx_calm;
    int                 errors;
    longint             cycles;

    three_stem_music_crossfade_mixer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .mix_valid   (mix_valid),
        .mix_stall   (mix_stall),
        .mix         (mix)
    );

    always #2 clk = ~clk;

    function automatic tsmix_pkg::mix_t mix_frame(tsmix_pkg::frame_t f);
        logic signed [15:0] sl[tsmix_pkg::STEMS];
        logic signed [15:0] sr[tsmix_pkg::STEMS];
        longint             sum_l;
        longint             sum_r;
        int                 m;
        tsmix_pkg::mix_t    r;
        sl = '{f.stem0_left, f.stem1_left, f.stem2_left};
        sr = '{f.stem0_right, f.stem1_right, f.stem2_right};
        sum_l = 0;
        sum_r = 0;
        if (frame_ph == tsmix_pkg::STEP_PHASE)
        begin
            if (int'(f.target_mix) > int'(mix_pos))
                mix_pos = mix_pos + 16'sd1;
            else
                mix_pos = mix_pos - 16'sd1;
        end
        frame_ph = frame_ph + 2'd1;
        for (int j = 0; j < tsmix_pkg::STEMS; j++)
        begin
            m = int'(mix_pos) - j * tsmix_pkg::UNITY;
            if (m > tsmix_pkg::UNITY)
                m = tsmix_pkg::PEAK_SPAN - m;
            if (m < 0)
                m = 0;
            sum_l += (longint'(sl[j]) * m) / tsmix_pkg::UNITY;
            sum_r += (longint'(sr[j]) * m) / tsmix_pkg::UNITY;
        end
        r.mixed_left  = sum_l[15:0];
        r.mixed_right = sum_r[15:0];
        return r;
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int idle_len(inout int calm);
        int p;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        p = $urandom_range(0, 999);
        if (p < 5)
        begin
            calm = $urandom_range(20, 200);
            return 0;
        end
        if (p < 600)
            return 0;
        if (p < 900)
            return $urandom_range(1, 3);
        if (p < 990)
            return $urandom_range(4, 10);
        return $urandom_range(16, 48);
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tsmix_pkg::frame_t rand_frame(logic [14:0] target);
        tsmix_pkg::frame_t f;
        f.target_mix  = target;
        f.stem0_left  = rand_sample();
        f.stem0_right = rand_sample();
        f.stem1_left  = rand_sample();
        f.stem1_right = rand_sample();
        f.stem2_left  = rand_sample();
        f.stem2_right = rand_sample();
        return f;
    endfunction

    task automatic push_frame(tsmix_pkg::frame_t f, bit drain);
        pending_t p;
        p.f     = f;
        p.drain = drain;
        pending_frames.push_back(p);
    endtask

    // request side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!frame_valid || frame_acc)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    frame_valid <= 1'b0;
                end
                else if (pending_frames.size() > 0 &&
                         !(pending_frames[0].drain && expected_mix.size() > 0))
                begin
                    frame       <= pending_frames[0].f;
                    frame_valid <= 1'b1;
                    void'(pending_frames.pop_front());
                    gap_left = idle_len(tx_calm);
                end
                else
                begin
                    frame_valid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                mix_stall <= 1'b1;
            end
            else
            begin
                mix_stall <= 1'b0;
                stall_left = idle_len(rx_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        frame_acc <= frame_valid && !frame_stall;
        if (rst_n && frame_valid && !frame_stall)
            expected_mix.push_back(mix_frame(frame));
        if (rst_n && mix_valid && !mix_stall)
        begin
            if (expected_mix.size() == 0)
            begin
                $display("%0t: unexpected mix result L=%0d R=%0d", $time,
                         mix.mixed_left, mix.mixed_right);
                errors++;
            end
            else
            begin
                if (mix.mixed_left !== expected_mix[0].mixed_left)
                begin
                    $display("%0t: mixed_left expected %0d actual %0d", $time,
                             expected_mix[0].mixed_left, mix.mixed_left);
                    errors++;
                end
                if (mix.mixed_right !== expected_mix[0].mixed_right)
                begin
                    $display("%0t: mixed_right expected %0d actual %0d", $time,
                             expected_mix[0].mixed_right, mix.mixed_right);
                    errors++;
                end
                void'(expected_mix.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("three_stem_music_crossfade_mixer test failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0]       edges[5];
        tsmix_pkg::frame_t f;
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        clk         = 1'b0;
        rst_n       = 1'b0;
        frame_valid = 1'b0;
        frame       = '0;
        mix_stall   = 1'b0;
        frame_acc   = 1'b0;
        mix_pos     = '0;
        frame_ph    = '0;
        gap_left    = 0;
        stall_left  = 0;
        tx_calm     = 0;
        rx_calm     = 0;
        errors      = 0;
        cycles      = 0;

        // target 0 first: mix falls to -1, all gains zero
        for (int i = 0; i < 24; i++)
        begin
            case (i % 4)
                0: f.target_mix = 15'd0;
                1: f.target_mix = 15'h7FFF;
                2: f.target_mix = 15'd16384;
                default: f.target_mix = 15'd8192;
            endcase
            if (i < 4)
                f.target_mix = 15'd0;
            f.stem0_left  = edges[i % 5];
            f.stem0_right = edges[(i + 1) % 5];
            f.stem1_left  = edges[(i + 2) % 5];
            f.stem1_right = edges[(i + 3) % 5];
            f.stem2_left  = edges[(i + 4) % 5];
            f.stem2_right = edges[i % 5];
            if (i >= 12)
                f.target_mix = 15'd40;
            push_frame(f, 1'b0);
        end

        for (int i = 0; i < RANDOM_FRAMES; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                push_frame(rand_frame(15'($urandom_range(0, 300))), i == 350);
            else
                push_frame(rand_frame(15'($urandom)), i == 350);
        end

        // steady climb toward the top target
        for (int i = 0; i < SWEEP_FRAMES; i++)
            push_frame(rand_frame(15'h7FFF), i == 0);

        for (int i = 0; i < HIGH_FRAMES; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                push_frame(rand_frame(15'($urandom_range(16384, 32767))), i == 0);
            else
                push_frame(rand_frame(15'($urandom)), i == 0);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_frames.size() > 0 || frame_valid || expected_mix.size() > 0)
            @(posedge clk);
        repeat (LATENCY * 4) @(posedge clk);

        if (errors == 0)
            $display("three_stem_music_crossfade_mixer test passed");
        else
            $display("three_stem_music_crossfade_mixer test failed");
        $finish;
    end

endmodule
